### hw/rtl/idalloc_pkg.sv
package idalloc_pkg;

    localparam int ID_W     = 10;
    localparam int CAPACITY = 2 ** ID_W;
    localparam int CNT_W    = ID_W + 1;

    typedef logic [ID_W-1:0]  id_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_QUERY   = 2'd2,
        FUNC_NOP     = 2'd3
    } func_t;

    localparam cnt_t CAP_CNT = cnt_t'(CAPACITY);

endpackage

### hw/rtl/id_allocator_with_free_fifo.sv
// ID allocator with a free FIFO.
// Input channel (s_valid/s_ready): one request per transaction, s_func selects
// allocate, release of s_entry_id, query of s_entry_id, or no operation.
// Result channel (m_valid/m_ready): exactly one result per request, in order:
// granted or echoed ID, ok, is_free and the live ID count after the request.
// Allocate reuses the oldest released ID first, then draws from a high-water
// counter; it fails (ok=0) when all IDs are live.
// An accepted request is first held in the input register; its result is then
// captured in the result register.
// Throughput: one request per cycle while m_ready is high; the FIFO head word and
// the free mark are read from simple dual-port memories ahead of use, with one-deep
// write forwarding, so back-to-back requests never stall on memory hazards.
// When m_ready is low the result register holds and the input register fills;
// s_ready then drops until the result is taken.
// Reset (aresetn, synchronous, active low): counters and FIFO pointers clear;
// no memory clearing pass is needed, so requests are taken the cycle after
// reset is released.
module id_allocator_with_free_fifo
    import idalloc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_func,
    input  logic [ID_W-1:0]  s_entry_id,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [ID_W-1:0]  m_result_id,
    output logic             m_ok,
    output logic             m_is_free,
    output logic [CNT_W-1:0] m_live_count
);

    // storage
    id_t  fifo_mem [CAPACITY];
    logic mark_mem [CAPACITY];

    // input stage
    logic  s1_valid_reg;
    func_t s1_func_reg;
    id_t   s1_id_reg;

    // state
    cnt_t hw_reg, hw_next;
    id_t  head_reg, head_next;
    id_t  tail_reg, tail_next;
    cnt_t level_reg, level_next;

    // memory read ports and forwarding
    id_t  fifo_rd_reg;
    logic byp_valid_reg;
    id_t  byp_data_reg;
    logic mark_rd_reg;
    logic fwd_valid_reg;
    id_t  fwd_addr_reg;
    logic fwd_data_reg;

    // output stage
    logic m_valid_reg;
    id_t  result_id_reg;
    logic ok_reg;
    logic is_free_reg;
    cnt_t live_reg;

    logic s1_fire;
    logic s_take;
    id_t  mark_rd_addr;
    id_t  head_data;
    logic mark_cur;

    logic mark_we;
    id_t  mark_waddr;
    logic mark_wdata;
    logic fifo_we;

    id_t  rid;
    logic ok;
    logic is_free;

    assign s1_fire = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_fire;
    assign s_take  = s_valid && s_ready;

    // address of the item that sits in the input register next cycle
    assign mark_rd_addr = s_take ? s_entry_id : s1_id_reg;

    assign head_data = byp_valid_reg ? byp_data_reg : fifo_rd_reg;
    assign mark_cur  = (fwd_valid_reg && (fwd_addr_reg == s1_id_reg)) ? fwd_data_reg
                                                                      : mark_rd_reg;

    always_comb begin
        hw_next    = hw_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        level_next = level_reg;
        mark_we    = 1'b0;
        mark_waddr = s1_id_reg;
        mark_wdata = 1'b0;
        fifo_we    = 1'b0;
        rid        = s1_id_reg;
        ok         = 1'b0;
        is_free    = 1'b0;
        unique case (s1_func_reg)
            FUNC_ALLOC: begin
                rid = '0;
                if (level_reg != '0) begin
                    rid        = head_data;
                    head_next  = head_reg + id_t'(1);
                    level_next = level_reg - cnt_t'(1);
                    mark_we    = 1'b1;
                    mark_waddr = head_data;
                    ok         = 1'b1;
                end else if (hw_reg < CAP_CNT) begin
                    // fresh ID: clear its mark, memory content is unknown
                    rid        = hw_reg[ID_W-1:0];
                    hw_next    = hw_reg + cnt_t'(1);
                    mark_we    = 1'b1;
                    mark_waddr = hw_reg[ID_W-1:0];
                    ok         = 1'b1;
                end
            end
            FUNC_RELEASE: begin
                if ((cnt_t'(s1_id_reg) < hw_reg) && !mark_cur && (level_reg < CAP_CNT)) begin
                    mark_we    = 1'b1;
                    mark_wdata = 1'b1;
                    fifo_we    = 1'b1;
                    tail_next  = tail_reg + id_t'(1);
                    level_next = level_reg + cnt_t'(1);
                    ok         = 1'b1;
                end
            end
            FUNC_QUERY: begin
                ok      = 1'b1;
                is_free = (cnt_t'(s1_id_reg) >= hw_reg) || mark_cur;
            end
            default: begin
            end
        endcase
        if (!s1_fire) begin
            hw_next    = hw_reg;
            head_next  = head_reg;
            tail_next  = tail_reg;
            level_next = level_reg;
            mark_we    = 1'b0;
            fifo_we    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mark_we) begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        mark_rd_reg <= mark_mem[mark_rd_addr];
        if (fifo_we) begin
            fifo_mem[tail_reg] <= s1_id_reg;
        end
        fifo_rd_reg <= fifo_mem[head_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            hw_reg        <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            level_reg     <= '0;
            byp_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s1_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            hw_reg        <= hw_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            level_reg     <= level_next;
            byp_valid_reg <= fifo_we && (tail_reg == head_next);
            fwd_valid_reg <= mark_we;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            s1_func_reg <= func_t'(s_func);
            s1_id_reg   <= s_entry_id;
        end
        byp_data_reg <= s1_id_reg;
        fwd_addr_reg <= mark_waddr;
        fwd_data_reg <= mark_wdata;
        if (s1_fire) begin
            result_id_reg <= rid;
            ok_reg        <= ok;
            is_free_reg   <= is_free;
            live_reg      <= hw_next - level_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_result_id  = result_id_reg;
    assign m_ok         = ok_reg;
    assign m_is_free    = is_free_reg;
    assign m_live_count = live_reg;

endmodule

### tb/idalloc_checker.sv
`timescale 1ns / 100ps

module idalloc_checker
    import idalloc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic [1:0]       s_func,
    input  logic [ID_W-1:0]  s_entry_id,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic [ID_W-1:0]  m_result_id,
    input  logic             m_ok,
    input  logic             m_is_free,
    input  logic [CNT_W-1:0] m_live_count,
    output int               fail_count,
    output int               outstanding
);

    typedef struct {
        id_t  result_id;
        logic ok;
        logic is_free;
        cnt_t live_count;
    } reply_t;

    reply_t replies_due[$];

    // shadow allocator state
    cnt_t high_water;
    cnt_t fifo_level;
    id_t  fifo_head;
    id_t  fifo_tail;
    id_t  free_ids [CAPACITY];
    logic freed    [CAPACITY];

    function automatic reply_t serve_request(logic [1:0] func, id_t id);
        reply_t r;
        r.result_id = id;
        r.ok        = 1'b0;
        r.is_free   = 1'b0;
        case (func_t'(func))
            FUNC_ALLOC: begin
                r.result_id = '0;
                if (fifo_level != '0) begin
                    r.result_id = free_ids[fifo_head];
                    freed[r.result_id] = 1'b0;
                    fifo_head  = fifo_head + 1'b1;
                    fifo_level = fifo_level - 1'b1;
                    r.ok = 1'b1;
                end else if (high_water < CAP_CNT) begin
                    r.result_id = high_water[ID_W-1:0];
                    high_water  = high_water + 1'b1;
                    r.ok = 1'b1;
                end
            end
            FUNC_RELEASE: begin
                if (cnt_t'(id) < high_water && !freed[id] && fifo_level < CAP_CNT) begin
                    freed[id] = 1'b1;
                    free_ids[fifo_tail] = id;
                    fifo_tail  = fifo_tail + 1'b1;
                    fifo_level = fifo_level + 1'b1;
                    r.ok = 1'b1;
                end
            end
            FUNC_QUERY: begin
                // every ID_W-bit id is below capacity
                r.ok      = 1'b1;
                r.is_free = (cnt_t'(id) >= high_water) || freed[id];
            end
            default: ;
        endcase
        r.live_count = high_water - fifo_level;
        return r;
    endfunction

    always @(posedge aclk) begin
        reply_t want;
        int     errs;
        errs = 0;
        if (!aresetn) begin
            high_water = '0;
            fifo_level = '0;
            fifo_head  = '0;
            fifo_tail  = '0;
            foreach (freed[i]) freed[i] = 1'b0;
            replies_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (replies_due.size() == 0) begin
                    $error("result transaction with nothing pending: result_id %0d",
                           m_result_id);
                    errs++;
                end else begin
                    want = replies_due[0];
                    replies_due.delete(0);
                    if (m_result_id !== want.result_id) begin
                        $error("result_id: expected %0d, actual %0d", want.result_id, m_result_id);
                        errs++;
                    end
                    if (m_ok !== want.ok) begin
                        $error("ok: expected %0d, actual %0d", want.ok, m_ok);
                        errs++;
                    end
                    if (m_is_free !== want.is_free) begin
                        $error("is_free: expected %0d, actual %0d", want.is_free, m_is_free);
                        errs++;
                    end
                    if (m_live_count !== want.live_count) begin
                        $error("live_count: expected %0d, actual %0d",
                               want.live_count, m_live_count);
                        errs++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                replies_due.insert(replies_due.size(), serve_request(s_func, s_entry_id));
            end
        end
        fail_count  <= fail_count + errs;
        outstanding <= replies_due.size();
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import idalloc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;

    logic             aclk       = 1'b0;
    logic             aresetn    = 1'b0;
    logic             s_valid    = 1'b0;
    logic [1:0]       s_func     = FUNC_ALLOC;
    logic [ID_W-1:0]  s_entry_id = '0;
    logic             m_ready    = 1'b0;
    logic             s_ready;
    logic             m_valid;
    logic [ID_W-1:0]  m_result_id;
    logic             m_ok;
    logic             m_is_free;
    logic [CNT_W-1:0] m_live_count;

    int   fail_count;
    int   outstanding;
    int   cycle_count = 0;
    int   send_idle   = 0;
    int   recv_idle   = 0;
    int   allocs_sent = 0;
    logic hold_req    = 1'b0;
    logic hold_done   = 1'b0;
    int   hold_left   = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    id_allocator_with_free_fifo u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_entry_id   (s_entry_id),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_result_id  (m_result_id),
        .m_ok         (m_ok),
        .m_is_free    (m_is_free),
        .m_live_count (m_live_count)
    );

    idalloc_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_entry_id   (s_entry_id),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_result_id  (m_result_id),
        .m_ok         (m_ok),
        .m_is_free    (m_is_free),
        .m_live_count (m_live_count),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    // receiver: random backpressure plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_request(input func_t func, input id_t id);
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_valid    <= 1'b1;
        s_func     <= func;
        s_entry_id <= id;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (func == FUNC_ALLOC) allocs_sent++;
    endtask

    // ids biased toward the range handed out so far, so releases mostly land
    task automatic send_random_request();
        int  pick;
        id_t id;
        pick = $urandom_range(99);
        if ($urandom_range(3) != 0)
            id = id_t'($urandom_range(allocs_sent > CAPACITY - 1 ? CAPACITY - 1 : allocs_sent));
        else
            id = id_t'($urandom_range(CAPACITY - 1));
        if (pick < 45)
            send_request(FUNC_ALLOC, id);
        else if (pick < 75)
            send_request(FUNC_RELEASE, id);
        else if (pick < 95)
            send_request(FUNC_QUERY, id);
        else
            send_request(FUNC_NOP, id);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(FUNC_QUERY,   10'd0);      // never allocated: free
        send_request(FUNC_QUERY,   10'd1023);
        send_request(FUNC_RELEASE, 10'd0);      // not yet allocated
        send_request(FUNC_ALLOC,   10'd1023);
        send_request(FUNC_ALLOC,   10'd0);
        send_request(FUNC_ALLOC,   10'd512);
        send_request(FUNC_RELEASE, 10'd1);
        send_request(FUNC_RELEASE, 10'd1);      // double release
        send_request(FUNC_QUERY,   10'd1);
        send_request(FUNC_QUERY,   10'd0);
        send_request(FUNC_RELEASE, 10'd500);
        send_request(FUNC_RELEASE, 10'd1023);
        send_request(FUNC_NOP,     10'd1023);
        send_request(FUNC_NOP,     10'd0);
        send_request(FUNC_ALLOC,   10'd0);      // reuses 1
        send_request(FUNC_RELEASE, 10'd2);
        send_request(FUNC_RELEASE, 10'd0);
        send_request(FUNC_ALLOC,   10'd341);    // oldest freed first
        send_request(FUNC_ALLOC,   10'd682);
        send_request(FUNC_ALLOC,   10'd0);      // counter again
        send_request(FUNC_QUERY,   10'd3);
        send_request(FUNC_QUERY,   10'd4);
        wait_for_results();

        send_idle = 19;
        recv_idle = 71;
        for (int i = 0; i < 50; i++) begin
            if (i == 15) hold_req <= 1'b1;
            send_random_request();
        end
        wait_for_results();

        send_idle = 71;
        recv_idle = 19;
        repeat (50) send_random_request();
        wait_for_results();

        send_idle = 0;
        recv_idle = 0;
        // run the allocator dry, then churn with every id live
        repeat (CAPACITY - int'(m_live_count) + 8)
            send_request(FUNC_ALLOC, id_t'($urandom_range(CAPACITY - 1)));
        repeat (20) send_random_request();
        wait_for_results();

        repeat (10) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
